/* hdl/mdms_pkg.sv */
// Shared types, codes and reset values for the motor drive mode sequencer.
package mdms_pkg;

    // Field widths
    localparam int MeasW  = 16;
    localparam int MagW   = MeasW + 1;
    localparam int LevelW = 15;
    localparam int ModeW  = 2;
    localparam int DivW   = 8;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = LevelW;

    // Drive states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ALIGN = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_FAULT = 2'd3;

    // Control modes
    localparam logic [ModeW-1:0] MODE_NORMAL     = 2'd0;
    localparam logic [ModeW-1:0] MODE_DUTY_TEST  = 2'd1;
    localparam logic [ModeW-1:0] MODE_CONST_VOLT = 2'd2;
    localparam logic [ModeW-1:0] MODE_ALIGN_ONLY = 2'd3;

    // Register indexes
    localparam logic [CfgIdxW-1:0] REG_CONTROL_MODE      = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_OVERVOLTAGE_LEVEL = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_OVERCURRENT_LEVEL = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_OVERSPEED_LEVEL   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_START_VOLTAGE_MIN = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_RUN_VOLTAGE_MIN   = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_SPEED_LOOP_DIVIDE = 3'd6;

    // Register reset values
    localparam logic [ModeW-1:0]  RST_CONTROL_MODE = MODE_NORMAL;
    localparam logic [LevelW-1:0] RST_LIMIT_LEVEL  = 15'd32767;
    localparam logic [LevelW-1:0] RST_START_VMIN   = 15'd256;   // 4 V
    localparam logic [LevelW-1:0] RST_RUN_VMIN     = 15'd640;   // 10 V
    localparam logic [DivW-1:0]   RST_SPEED_DIVIDE = 8'd39;

    // One result transaction
    typedef struct packed {
        logic [1:0] drive_state;
        logic       pwm_on;
        logic       bootstrap_strobe;
        logic       align_strobe;
        logic       current_loop_strobe;
        logic       observer_strobe;
        logic       speed_loop_strobe;
        logic       controller_init;
        logic       soft_fault;
        logic       trip_fault;
        logic       start_flag;
    } result_t;

    // Saturation-free magnitude: -32768 gives 32768 in the extra bit
    function automatic logic [MagW-1:0] mag16(input logic signed [MeasW-1:0] v);
        logic [MagW-1:0] ext;
        ext = {v[MeasW-1], v};
        return v[MeasW-1] ? (MagW'(0) - ext) : ext;
    endfunction

endpackage

/* hdl/mdms_fault_check.sv */
// Over-limit detection on bus voltage, phase currents and speed.
module mdms_fault_check (
    input  logic signed [mdms_pkg::MeasW-1:0]  bus_voltage,
    input  logic signed [mdms_pkg::MeasW-1:0]  current_a,
    input  logic signed [mdms_pkg::MeasW-1:0]  current_b,
    input  logic signed [mdms_pkg::MeasW-1:0]  current_c,
    input  logic signed [mdms_pkg::MeasW-1:0]  speed_rpm,
    input  logic        [mdms_pkg::LevelW-1:0] overvoltage_level,
    input  logic        [mdms_pkg::LevelW-1:0] overcurrent_level,
    input  logic        [mdms_pkg::LevelW-1:0] overspeed_level,
    output logic                               over_limit
);
    import mdms_pkg::*;

    logic [MagW-1:0] ov_lim;
    logic [MagW-1:0] oc_lim;
    logic [MagW-1:0] os_lim;

    // Thresholds widened to magnitude width
    assign ov_lim = {2'b00, overvoltage_level};
    assign oc_lim = {2'b00, overcurrent_level};
    assign os_lim = {2'b00, overspeed_level};

    // Any magnitude reaching its threshold trips
    assign over_limit = (mag16(bus_voltage) >= ov_lim)
                     || (mag16(current_a)   >= oc_lim)
                     || (mag16(current_b)   >= oc_lim)
                     || (mag16(current_c)   >= oc_lim)
                     || (mag16(speed_rpm)   >= os_lim);

endmodule

/* hdl/motor_drive_mode_sequencer.sv */
// An accepted transaction passes from the input register to the result register, setting out_valid.
// Throughput: one transaction per cycle while out_stall is low; input reg, decision logic, result reg.
// The input side stalls only while a result waits in the output register and out_stall is high.
// Reset (rst_n low, asynchronous): state IDLE, latches and divider cleared, pipeline empty,
// configuration registers back to their defaults.
module motor_drive_mode_sequencer (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration port
    input  logic                                cfg_write,
    input  logic [mdms_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [mdms_pkg::CfgDataW-1:0]       cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                start_request,
    input  logic                                reset_request,
    input  logic                                trip_event,
    input  logic                                bootstrap_done,
    input  logic                                align_done,
    input  logic signed [mdms_pkg::MeasW-1:0]   bus_voltage,
    input  logic signed [mdms_pkg::MeasW-1:0]   current_a,
    input  logic signed [mdms_pkg::MeasW-1:0]   current_b,
    input  logic signed [mdms_pkg::MeasW-1:0]   current_c,
    input  logic signed [mdms_pkg::MeasW-1:0]   speed_rpm,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          drive_state,
    output logic                                pwm_on,
    output logic                                bootstrap_strobe,
    output logic                                align_strobe,
    output logic                                current_loop_strobe,
    output logic                                observer_strobe,
    output logic                                speed_loop_strobe,
    output logic                                controller_init,
    output logic                                soft_fault,
    output logic                                trip_fault,
    output logic                                start_flag
);
    import mdms_pkg::*;

    // Configuration registers
    logic [ModeW-1:0]  control_mode_reg;
    logic [LevelW-1:0] overvoltage_level_reg;
    logic [LevelW-1:0] overcurrent_level_reg;
    logic [LevelW-1:0] overspeed_level_reg;
    logic [LevelW-1:0] start_voltage_min_reg;
    logic [LevelW-1:0] run_voltage_min_reg;
    logic [DivW-1:0]   speed_loop_divide_reg;

    // Input register
    logic                     s1_valid_reg;
    logic                     s1_start_reg;
    logic                     s1_reset_reg;
    logic                     s1_trip_reg;
    logic                     s1_boot_done_reg;
    logic                     s1_align_done_reg;
    logic signed [MeasW-1:0]  s1_bus_reg;
    logic signed [MeasW-1:0]  s1_cur_a_reg;
    logic signed [MeasW-1:0]  s1_cur_b_reg;
    logic signed [MeasW-1:0]  s1_cur_c_reg;
    logic signed [MeasW-1:0]  s1_speed_reg;

    // Sequencer state
    logic [1:0]      mode_next_reg;
    logic [1:0]      mode_cur_reg;
    logic            start_latch_reg;
    logic            soft_latch_reg;
    logic            trip_latch_reg;
    logic [DivW-1:0] divider_reg;

    logic [1:0]      mode_next_next;
    logic            start_latch_next;
    logic            soft_latch_next;
    logic            trip_latch_next;
    logic [DivW-1:0] divider_next;

    // Result register
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;

    logic accept;
    logic advance;
    logic over_limit;
    logic faulted;
    logic bus_below_start;
    logic bus_below_run;

    // Handshake
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_mode_reg      <= RST_CONTROL_MODE;
            overvoltage_level_reg <= RST_LIMIT_LEVEL;
            overcurrent_level_reg <= RST_LIMIT_LEVEL;
            overspeed_level_reg   <= RST_LIMIT_LEVEL;
            start_voltage_min_reg <= RST_START_VMIN;
            run_voltage_min_reg   <= RST_RUN_VMIN;
            speed_loop_divide_reg <= RST_SPEED_DIVIDE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CONTROL_MODE:      control_mode_reg      <= cfg_data[ModeW-1:0];
                REG_OVERVOLTAGE_LEVEL: overvoltage_level_reg <= cfg_data;
                REG_OVERCURRENT_LEVEL: overcurrent_level_reg <= cfg_data;
                REG_OVERSPEED_LEVEL:   overspeed_level_reg   <= cfg_data;
                REG_START_VOLTAGE_MIN: start_voltage_min_reg <= cfg_data;
                REG_RUN_VOLTAGE_MIN:   run_voltage_min_reg   <= cfg_data;
                REG_SPEED_LOOP_DIVIDE: speed_loop_divide_reg <= cfg_data[DivW-1:0];
                default: ;
            endcase
        end
    end

    // Input register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    // Input register: payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_start_reg      <= start_request;
            s1_reset_reg      <= reset_request;
            s1_trip_reg       <= trip_event;
            s1_boot_done_reg  <= bootstrap_done;
            s1_align_done_reg <= align_done;
            s1_bus_reg        <= bus_voltage;
            s1_cur_a_reg      <= current_a;
            s1_cur_b_reg      <= current_b;
            s1_cur_c_reg      <= current_c;
            s1_speed_reg      <= speed_rpm;
        end
    end

    // Threshold check
    mdms_fault_check u_fault_check (
        .bus_voltage       (s1_bus_reg),
        .current_a         (s1_cur_a_reg),
        .current_b         (s1_cur_b_reg),
        .current_c         (s1_cur_c_reg),
        .speed_rpm         (s1_speed_reg),
        .overvoltage_level (overvoltage_level_reg),
        .overcurrent_level (overcurrent_level_reg),
        .overspeed_level   (overspeed_level_reg),
        .over_limit        (over_limit)
    );

    // Signed bus compares; a negative bus is below any minimum
    assign bus_below_start = s1_bus_reg < $signed({1'b0, start_voltage_min_reg});
    assign bus_below_run   = s1_bus_reg < $signed({1'b0, run_voltage_min_reg});

    // One control tick
    always_comb
    begin
        result_next      = '0;
        start_latch_next = start_latch_reg | s1_start_reg;
        trip_latch_next  = trip_latch_reg | s1_trip_reg;
        soft_latch_next  = soft_latch_reg | over_limit;
        mode_next_next   = mode_next_reg;
        divider_next     = divider_reg;

        // reset request wins over everything set above
        if (s1_reset_reg)
        begin
            start_latch_next            = 1'b0;
            mode_next_next              = ST_IDLE;
            soft_latch_next             = 1'b0;
            trip_latch_next             = 1'b0;
            result_next.controller_init = 1'b1;
        end

        faulted                 = soft_latch_next | trip_latch_next;
        result_next.drive_state = mode_next_next;

        unique case (result_next.drive_state)
            ST_IDLE:
            begin
                // entry into idle
                if (mode_cur_reg != ST_IDLE)
                begin
                    start_latch_next            = 1'b0;
                    result_next.controller_init = 1'b1;
                end
                priority if (bus_below_start)
                    mode_next_next = ST_IDLE;
                else if (faulted)
                    mode_next_next = ST_FAULT;
                else if (start_latch_next)
                begin
                    result_next.bootstrap_strobe = 1'b1;
                    if (!s1_boot_done_reg)
                        mode_next_next = ST_IDLE;
                    else if (control_mode_reg == MODE_DUTY_TEST
                             || control_mode_reg == MODE_CONST_VOLT)
                        mode_next_next = ST_RUN;
                    else
                        mode_next_next = ST_ALIGN;
                end
                else
                    mode_next_next = ST_IDLE;
            end
            ST_ALIGN:
            begin
                result_next.pwm_on              = 1'b1;
                result_next.align_strobe        = 1'b1;
                result_next.current_loop_strobe = 1'b1;
                // faults wait until idle or run
                priority if (!start_latch_next)
                    mode_next_next = ST_IDLE;
                else if (s1_align_done_reg)
                begin
                    if (control_mode_reg == MODE_ALIGN_ONLY)
                    begin
                        mode_next_next   = ST_IDLE;
                        start_latch_next = 1'b0;
                    end
                    else
                        mode_next_next = ST_RUN;
                end
                else
                    mode_next_next = ST_ALIGN;
            end
            ST_RUN:
            begin
                result_next.pwm_on              = 1'b1;
                result_next.observer_strobe     = 1'b1;
                result_next.current_loop_strobe = 1'b1;
                // speed loop divider: restart at one after the strobe
                if (divider_reg >= speed_loop_divide_reg)
                begin
                    result_next.speed_loop_strobe = 1'b1;
                    divider_next                  = DivW'(1);
                end
                else
                    divider_next = divider_reg + DivW'(1);
                priority if (faulted)
                    mode_next_next = ST_FAULT;
                else if (!start_latch_next || bus_below_run)
                    mode_next_next = ST_IDLE;
                else
                    mode_next_next = ST_RUN;
            end
            ST_FAULT:
            begin
                start_latch_next = 1'b0;
                mode_next_next   = ST_FAULT;
            end
            default: ;
        endcase

        result_next.soft_fault = soft_latch_next;
        result_next.trip_fault = trip_latch_next;
        result_next.start_flag = start_latch_next;
    end

    // State update on every tick that moves to the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_next_reg   <= ST_IDLE;
            mode_cur_reg    <= ST_IDLE;
            start_latch_reg <= 1'b0;
            soft_latch_reg  <= 1'b0;
            trip_latch_reg  <= 1'b0;
            divider_reg     <= '0;
        end
        else if (advance)
        begin
            mode_next_reg   <= mode_next_next;
            mode_cur_reg    <= result_next.drive_state;
            start_latch_reg <= start_latch_next;
            soft_latch_reg  <= soft_latch_next;
            trip_latch_reg  <= trip_latch_next;
            divider_reg     <= divider_next;
        end
    end

    // Output register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Output register: payload
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid           = out_valid_reg;
    assign drive_state         = result_reg.drive_state;
    assign pwm_on              = result_reg.pwm_on;
    assign bootstrap_strobe    = result_reg.bootstrap_strobe;
    assign align_strobe        = result_reg.align_strobe;
    assign current_loop_strobe = result_reg.current_loop_strobe;
    assign observer_strobe     = result_reg.observer_strobe;
    assign speed_loop_strobe   = result_reg.speed_loop_strobe;
    assign controller_init     = result_reg.controller_init;
    assign soft_fault          = result_reg.soft_fault;
    assign trip_fault          = result_reg.trip_fault;
    assign start_flag          = result_reg.start_flag;

`ifndef SYNTHESIS
    // switches on exactly in align and run
    a_pwm_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pwm_on == (drive_state == ST_ALIGN || drive_state == ST_RUN)))
        else $error("pwm_on disagrees with drive_state");

    // speed strobe only alongside the observer strobe
    a_speed_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && speed_loop_strobe) |-> observer_strobe)
        else $error("speed loop strobe outside run");

    // a reset request leaves the machine heading for idle with controllers reinitialised
    a_reset_request: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_reset_reg) |=> (mode_next_reg == ST_IDLE && out_valid
                                       && controller_init && !soft_fault && !trip_fault))
        else $error("reset request not honoured");

    // fault state never leaves a start flag set
    a_fault_start: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && drive_state == ST_FAULT) |-> !start_flag)
        else $error("start flag set in fault");
`endif

endmodule

/* tb/motor_drive_mode_sequencer_test.sv */
// Self-checking testbench for the motor drive mode sequencer: directed and random ticks.
module motor_drive_mode_sequencer_test;
    import mdms_pkg::*;

    // One control-period tick as driven on the input channel
    typedef struct {
        bit                      start_request;
        bit                      reset_request;
        bit                      trip_event;
        bit                      bootstrap_done;
        bit                      align_done;
        logic signed [MeasW-1:0] bus_voltage;
        logic signed [MeasW-1:0] current_a;
        logic signed [MeasW-1:0] current_b;
        logic signed [MeasW-1:0] current_c;
        logic signed [MeasW-1:0] speed_rpm;
    } tick_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write;
    logic [CfgIdxW-1:0]      cfg_index;
    logic [CfgDataW-1:0]     cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic                    start_request;
    logic                    reset_request;
    logic                    trip_event;
    logic                    bootstrap_done;
    logic                    align_done;
    logic signed [MeasW-1:0] bus_voltage;
    logic signed [MeasW-1:0] current_a;
    logic signed [MeasW-1:0] current_b;
    logic signed [MeasW-1:0] current_c;
    logic signed [MeasW-1:0] speed_rpm;
    logic                    out_valid;
    logic                    out_stall;
    logic [1:0]              drive_state;
    logic                    pwm_on;
    logic                    bootstrap_strobe;
    logic                    align_strobe;
    logic                    current_loop_strobe;
    logic                    observer_strobe;
    logic                    speed_loop_strobe;
    logic                    controller_init;
    logic                    soft_fault;
    logic                    trip_fault;
    logic                    start_flag;

    // Predictor copy of the registers
    logic [ModeW-1:0] drive_mode = RST_CONTROL_MODE;
    int ov_level   = RST_LIMIT_LEVEL;
    int oc_level   = RST_LIMIT_LEVEL;
    int spd_level  = RST_LIMIT_LEVEL;
    int start_vmin = RST_START_VMIN;
    int run_vmin   = RST_RUN_VMIN;
    int loop_count = RST_SPEED_DIVIDE;

    // Predictor copy of the sequencer state
    logic [1:0]      queued_state = ST_IDLE;
    logic [1:0]      acting_state = ST_IDLE;
    bit              start_latch;
    bit              soft_latch;
    bit              trip_latch;
    logic [DivW-1:0] speed_count = '0;

    result_t awaited_results[$];

    int mismatches;
    int ticks_sent;
    int results_checked;
    int speed_strobes;
    int settings_used;
    bit steady;

    motor_drive_mode_sequencer i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write           (cfg_write),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .start_request       (start_request),
        .reset_request       (reset_request),
        .trip_event          (trip_event),
        .bootstrap_done      (bootstrap_done),
        .align_done          (align_done),
        .bus_voltage         (bus_voltage),
        .current_a           (current_a),
        .current_b           (current_b),
        .current_c           (current_c),
        .speed_rpm           (speed_rpm),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .drive_state         (drive_state),
        .pwm_on              (pwm_on),
        .bootstrap_strobe    (bootstrap_strobe),
        .align_strobe        (align_strobe),
        .current_loop_strobe (current_loop_strobe),
        .observer_strobe     (observer_strobe),
        .speed_loop_strobe   (speed_loop_strobe),
        .controller_init     (controller_init),
        .soft_fault          (soft_fault),
        .trip_fault          (trip_fault),
        .start_flag          (start_flag)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #20_000_000;
        $display("motor_drive_mode_sequencer test failed");
        $finish;
    end

    // Magnitude without saturation: -32768 gives 32768
    function automatic int magnitude(logic signed [MeasW-1:0] v);
        int s;
        s = v;
        return (s < 0) ? -s : s;
    endfunction

    // Advance the predicted sequencer by one tick and return its result
    function automatic result_t advance_sequencer(tick_t t);
        result_t    r;
        logic [1:0] was;
        bit         faulted;
        int         vbus;
        r = '0;
        vbus = t.bus_voltage;

        if (t.start_request)
            start_latch = 1'b1;
        if (t.trip_event)
            trip_latch = 1'b1;
        if (!soft_latch && (magnitude(t.bus_voltage) >= ov_level ||
                            magnitude(t.current_a) >= oc_level ||
                            magnitude(t.current_b) >= oc_level ||
                            magnitude(t.current_c) >= oc_level ||
                            magnitude(t.speed_rpm) >= spd_level))
            soft_latch = 1'b1;

        // reset request wins over everything latched this tick
        if (t.reset_request)
        begin
            start_latch = 1'b0;
            soft_latch = 1'b0;
            trip_latch = 1'b0;
            queued_state = ST_IDLE;
            r.controller_init = 1'b1;
        end

        was = acting_state;
        acting_state = queued_state;
        faulted = soft_latch | trip_latch;

        case (acting_state)
            ST_IDLE:
            begin
                if (was != ST_IDLE)
                begin
                    start_latch = 1'b0;
                    r.controller_init = 1'b1;
                end
                if (vbus < start_vmin)
                    queued_state = ST_IDLE;
                else if (faulted)
                    queued_state = ST_FAULT;
                else if (start_latch)
                begin
                    r.bootstrap_strobe = 1'b1;
                    if (!t.bootstrap_done)
                        queued_state = ST_IDLE;
                    else if (drive_mode == MODE_DUTY_TEST || drive_mode == MODE_CONST_VOLT)
                        queued_state = ST_RUN;
                    else
                        queued_state = ST_ALIGN;
                end
                else
                    queued_state = ST_IDLE;
            end
            ST_ALIGN:
            begin
                r.pwm_on = 1'b1;
                r.align_strobe = 1'b1;
                r.current_loop_strobe = 1'b1;
                // faults are not acted on while aligning
                if (!start_latch)
                    queued_state = ST_IDLE;
                else if (t.align_done)
                begin
                    if (drive_mode == MODE_ALIGN_ONLY)
                    begin
                        queued_state = ST_IDLE;
                        start_latch = 1'b0;
                    end
                    else
                        queued_state = ST_RUN;
                end
                else
                    queued_state = ST_ALIGN;
            end
            ST_RUN:
            begin
                r.pwm_on = 1'b1;
                r.observer_strobe = 1'b1;
                r.current_loop_strobe = 1'b1;
                if (speed_count >= loop_count)
                begin
                    r.speed_loop_strobe = 1'b1;
                    speed_count = '0;
                end
                if (faulted)
                    queued_state = ST_FAULT;
                else if (!start_latch || vbus < run_vmin)
                    queued_state = ST_IDLE;
                else
                    queued_state = ST_RUN;
                speed_count = speed_count + 1'b1;
            end
            default:
            begin
                start_latch = 1'b0;
                queued_state = ST_FAULT;
            end
        endcase

        r.drive_state = acting_state;
        r.soft_fault = soft_latch;
        r.trip_fault = trip_latch;
        r.start_flag = start_latch;
        return r;
    endfunction

    // Idle cycles before a transaction, none during steady stretches
    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic tick_t tick_of(bit st, bit rq, bit tr, bit bd, bit ad,
                                      int bus, int ia, int ib, int ic, int spd);
        tick_t t;
        t.start_request = st;
        t.reset_request = rq;
        t.trip_event = tr;
        t.bootstrap_done = bd;
        t.align_done = ad;
        t.bus_voltage = MeasW'(bus);
        t.current_a = MeasW'(ia);
        t.current_b = MeasW'(ib);
        t.current_c = MeasW'(ic);
        t.speed_rpm = MeasW'(spd);
        return t;
    endfunction

    // Measurement kept below its threshold, either sign; any value for a zero threshold
    function automatic logic signed [MeasW-1:0] quiet_measurement(int level);
        int m;
        if (level == 0)
            return MeasW'($urandom);
        m = $urandom_range(0, level - 1);
        return MeasW'($urandom_range(0, 1) ? -m : m);
    endfunction

    // Mostly healthy ticks with random content; some noise and boundary hits
    function automatic tick_t random_tick();
        tick_t t;
        int    pick;
        int    lo;
        int    hi;
        int    edge_val;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            {t.start_request, t.reset_request, t.trip_event,
             t.bootstrap_done, t.align_done} = 5'($urandom);
            t.bus_voltage = MeasW'($urandom);
            t.current_a = MeasW'($urandom);
            t.current_b = MeasW'($urandom);
            t.current_c = MeasW'($urandom);
            t.speed_rpm = MeasW'($urandom);
            return t;
        end
        t.start_request = ($urandom_range(0, 9) == 0);
        t.reset_request = ($urandom_range(0, 39) == 0);
        t.trip_event = ($urandom_range(0, 149) == 0);
        t.bootstrap_done = $urandom_range(0, 1);
        t.align_done = ($urandom_range(0, 3) == 0);

        lo = (start_vmin > run_vmin) ? start_vmin : run_vmin;
        hi = ov_level - 1;
        if (pick < 88 && hi >= lo)
            t.bus_voltage = MeasW'($urandom_range(lo, hi));
        else if (pick < 96)
            t.bus_voltage = MeasW'($urandom_range(0, run_vmin));
        else
            t.bus_voltage = MeasW'($urandom | 32'h8000);

        t.current_a = quiet_measurement(oc_level);
        t.current_b = quiet_measurement(oc_level);
        t.current_c = quiet_measurement(oc_level);
        t.speed_rpm = quiet_measurement(spd_level);

        // now and then one measurement sits exactly on its threshold
        if ($urandom_range(0, 29) == 0)
        begin
            edge_val = $urandom_range(0, 1) ? -1 : 1;
            case ($urandom_range(0, 3))
                0: t.current_a = MeasW'(edge_val * oc_level);
                1: t.current_c = MeasW'(edge_val * oc_level);
                2: t.speed_rpm = MeasW'(edge_val * spd_level);
                default: t.bus_voltage = MeasW'(edge_val * ov_level);
            endcase
        end
        return t;
    endfunction

    // Send one tick and record its expected result once accepted
    task automatic send_tick(input tick_t t);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start_request <= t.start_request;
        reset_request <= t.reset_request;
        trip_event <= t.trip_event;
        bootstrap_done <= t.bootstrap_done;
        align_done <= t.align_done;
        bus_voltage <= t.bus_voltage;
        current_a <= t.current_a;
        current_b <= t.current_b;
        current_c <= t.current_c;
        speed_rpm <= t.speed_rpm;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        awaited_results.push_back(advance_sequencer(t));
        ticks_sent++;
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_expected();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (awaited_results.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        if (awaited_results.size() != 0)
        begin
            $display("%0t: outstanding results expected 0, actual %0d",
                     $time, awaited_results.size());
            mismatches++;
            awaited_results.delete();
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CfgDataW'(value);
        @(posedge clk);
        case (idx)
            REG_CONTROL_MODE:      drive_mode = ModeW'(value);
            REG_OVERVOLTAGE_LEVEL: ov_level = value;
            REG_OVERCURRENT_LEVEL: oc_level = value;
            REG_OVERSPEED_LEVEL:   spd_level = value;
            REG_START_VOLTAGE_MIN: start_vmin = value;
            REG_RUN_VOLTAGE_MIN:   run_vmin = value;
            REG_SPEED_LOOP_DIVIDE: loop_count = value;
            default: ;
        endcase
    endtask

    // Write every register; only called with the pipeline empty
    task automatic set_config(input logic [ModeW-1:0] mode, input int ov, input int oc,
                              input int spd, input int vstart, input int vrun, input int div);
        write_reg(REG_CONTROL_MODE, mode);
        write_reg(REG_OVERVOLTAGE_LEVEL, ov);
        write_reg(REG_OVERCURRENT_LEVEL, oc);
        write_reg(REG_OVERSPEED_LEVEL, spd);
        write_reg(REG_START_VOLTAGE_MIN, vstart);
        write_reg(REG_RUN_VOLTAGE_MIN, vrun);
        write_reg(REG_SPEED_LOOP_DIVIDE, div);
        cfg_write <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // Random traffic with steady stretches and a full drain half way
    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                steady = !steady;
            if (i == count / 2)
                drain_expected();
            send_tick(random_tick());
        end
    endtask

    // Normal start: bootstrap, align, run, drop out on a negative bus
    task automatic test_startup_path();
        send_tick(tick_of(0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_tick(tick_of(1, 0, 0, 0, 0, 100, 0, 0, 0, 0));
        send_tick(tick_of(0, 0, 0, 0, 0, 8000, 0, 0, 0, 0));
        send_tick(tick_of(0, 0, 0, 1, 0, 8000, 0, 0, 0, 0));
        send_tick(tick_of(0, 0, 0, 0, 0, 8000, 300, -300, 0, 1000));
        send_tick(tick_of(0, 0, 0, 0, 1, 8000, 0, 0, 0, 0));
        send_tick(tick_of(0, 0, 0, 0, 0, 8000, 120, -60, -60, 1500));
        send_tick(tick_of(0, 0, 0, 0, 0, 8000, -120, 60, 60, -1500));
        send_tick(tick_of(0, 0, 0, 0, 0, -1, 0, 0, 0, 0));
        send_tick(tick_of(0, 0, 0, 0, 0, 8000, 0, 0, 0, 0));
    endtask

    // Trip during align, acted on in run; fault is sticky; reset wins
    task automatic test_fault_handling();
        send_tick(tick_of(1, 0, 0, 1, 0, 8000, 0, 0, 0, 0));
        send_tick(tick_of(0, 0, 1, 0, 0, 8000, 0, 0, 0, 0));
        send_tick(tick_of(0, 0, 0, 0, 1, 8000, 0, 0, 0, 0));
        send_tick(tick_of(0, 0, 0, 0, 0, 8000, 0, 0, 0, 0));
        send_tick(tick_of(1, 0, 0, 0, 0, 8000, 0, 0, 0, 0));
        send_tick(tick_of(1, 1, 1, 0, 0, 8000, 0, 0, 0, 0));
    endtask

    // Full-scale measurements, including the most negative code
    task automatic test_measurement_extremes();
        send_tick(tick_of(0, 0, 0, 0, 0, 8000, -32768, 0, 0, 0));
        send_tick(tick_of(0, 1, 0, 0, 0, 8000, 0, 0, 0, 0));
        send_tick(tick_of(0, 0, 0, 0, 0, 8000, 0, 32767, 0, 0));
        send_tick(tick_of(0, 1, 0, 0, 0, 8000, 0, 0, 32767, 0));
        send_tick(tick_of(0, 0, 0, 0, 0, 8000, 0, 0, 0, -32768));
        send_tick(tick_of(0, 1, 0, 0, 0, 8000, 0, 0, 0, 0));
        send_tick(tick_of(0, 0, 0, 0, 0, -32768, 0, 0, 0, 0));
        send_tick(tick_of(0, 1, 0, 0, 0, 32767, 0, 0, 0, 0));
        send_tick(tick_of(0, 0, 0, 0, 0, 32767, 0, 0, 0, 0));
    endtask

    // Random operation across every control mode and divider extremes
    task automatic test_random_operation();
        drain_expected();
        run_random(250);
        drain_expected();
        set_config(MODE_DUTY_TEST, 20000, 12000, 9000, 1000, 1500, 1);
        run_random(250);
        drain_expected();
        set_config(MODE_CONST_VOLT, 30000, 25000, 30000, 0, 0, 255);
        run_random(350);
        drain_expected();
        set_config(MODE_ALIGN_ONLY, 5000, 3000, 4000, 2000, 2500, 10);
        run_random(200);
        drain_expected();
        set_config(MODE_NORMAL, 24000, 8000, 12000, 512, 900, 3);
        run_random(200);
    endtask

    // Zero thresholds trip on anything; maximum minima block every start
    task automatic test_threshold_extremes();
        drain_expected();
        set_config(MODE_NORMAL, 0, 0, 0, 256, 640, 39);
        run_random(20);
        drain_expected();
        set_config(MODE_DUTY_TEST, 32767, 32767, 32767, 32767, 32767, 255);
        run_random(20);
    endtask

    // Result side: random stall per transaction
    initial
    begin : result_sink
        int hold;
        out_stall <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            hold = draw_wait();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {drive_state, pwm_on, bootstrap_strobe, align_strobe, current_loop_strobe,
                   observer_strobe, speed_loop_strobe, controller_init, soft_fault,
                   trip_fault, start_flag};
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result expected none, actual state %0d", $time, drive_state);
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                compare_field("drive_state", want.drive_state, got.drive_state);
                compare_field("pwm_on", want.pwm_on, got.pwm_on);
                compare_field("bootstrap_strobe", want.bootstrap_strobe, got.bootstrap_strobe);
                compare_field("align_strobe", want.align_strobe, got.align_strobe);
                compare_field("current_loop_strobe", want.current_loop_strobe,
                              got.current_loop_strobe);
                compare_field("observer_strobe", want.observer_strobe, got.observer_strobe);
                compare_field("speed_loop_strobe", want.speed_loop_strobe,
                              got.speed_loop_strobe);
                compare_field("controller_init", want.controller_init, got.controller_init);
                compare_field("soft_fault", want.soft_fault, got.soft_fault);
                compare_field("trip_fault", want.trip_fault, got.trip_fault);
                compare_field("start_flag", want.start_flag, got.start_flag);
            end
            results_checked++;
            if (got.speed_loop_strobe)
                speed_strobes++;
        end
    end

    // Test sequence
    initial
    begin
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        start_request <= 1'b0;
        reset_request <= 1'b0;
        trip_event <= 1'b0;
        bootstrap_done <= 1'b0;
        align_done <= 1'b0;
        bus_voltage <= '0;
        current_a <= '0;
        current_b <= '0;
        current_c <= '0;
        speed_rpm <= '0;
        steady = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_startup_path();
        test_fault_handling();
        test_measurement_extremes();
        test_random_operation();
        test_threshold_extremes();

        drain_expected();
        repeat (5) @(posedge clk);
        $display("Checked %0d results from %0d ticks under %0d register settings.",
                 results_checked, ticks_sent, settings_used + 1);
        $display("All four control modes, threshold extremes and %0d speed strobes seen.",
                 speed_strobes);
        if (mismatches == 0)
            $display("motor_drive_mode_sequencer test passed");
        else
            $display("motor_drive_mode_sequencer test failed");
        $finish;
    end

endmodule
